// ----- design/fvd_pkg.sv -----
// Shared types, constants and command/status bundles of the face vertex deduplicator.
package fvd_pkg;

  localparam int unsigned MAX_VERTICES_DEF  = 65536;
  localparam int unsigned TABLE_ENTRIES_DEF = 131072;
  localparam int unsigned MAX_CORNERS_DEF   = 4;

  localparam int RAW_W   = 22;
  localparam int CNT_W   = 21;
  localparam int POS_W   = 20;
  localparam int REF_W   = 21;
  localparam int KEY_W   = POS_W + 2 * REF_W;
  localparam int IDX_W   = 16;
  localparam int ENTRY_W = 1 + KEY_W + IDX_W;
  localparam int HASH_W  = 48;
  localparam int MUL_W   = 27;
  localparam int MUL_STEPS = 3;

  localparam logic [MUL_W-1:0] HASH_K_POS = 27'd73856093;
  localparam logic [MUL_W-1:0] HASH_K_TEX = 27'd19349663;
  localparam logic [MUL_W-1:0] HASH_K_NRM = 27'd83492791;

  typedef enum logic [2:0] {
    KIND_VERTEX     = 3'd0,
    KIND_TRIANGLE   = 3'd1,
    KIND_BAD_CORNER = 3'd2,
    KIND_TOO_FEW    = 3'd3,
    KIND_TABLE_FULL = 3'd4
  } kind_t;

  typedef enum logic {
    OP_CORNER = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    EMIT_VERTEX,
    EMIT_TRIANGLE,
    EMIT_REJECT
  } emit_sel_t;

  typedef struct packed {
    logic      clr_start;
    logic      clr_step;
    logic      take_corner;
    logic      idx_rst;
    logic      idx_one;
    logic      idx_inc;
    logic      hash_start;
    logic      probe_start;
    logic      probe_read;
    logic      probe_next;
    logic      p1_record;
    logic      ins_write;
    logic      emit;
    emit_sel_t emit_sel;
    kind_t     rej_kind;
    logic      commit;
    logic      face_end;
  } fvd_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic too_few;
    logic bad;
    logic hash_busy;
    logic idx_last;
    logic probe_stop;
    logic full_fail;
    logic cur_new;
    logic tri_last;
    logic out_free;
  } fvd_status_t;

endpackage

// ----- design/fvd_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module fvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/fvd_datapath.sv -----
// Datapath: corner buffer, hash unit, probe walker, key table and result register.
module fvd_datapath
  import fvd_pkg::*;
#(
  parameter int unsigned MAX_VERTICES  = MAX_VERTICES_DEF,
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_CORNERS   = MAX_CORNERS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  fvd_cmd_t                cmd,
  output fvd_status_t             st,
  input  logic signed [RAW_W-1:0] raw_position,
  input  logic signed [RAW_W-1:0] raw_texcoord,
  input  logic signed [RAW_W-1:0] raw_normal,
  input  logic [CNT_W-1:0]        position_count,
  input  logic [CNT_W-1:0]        texcoord_count,
  input  logic [CNT_W-1:0]        normal_count,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              kind,
  output logic [IDX_W-1:0]        index_a,
  output logic [IDX_W-1:0]        index_b,
  output logic [IDX_W-1:0]        index_c,
  output logic [POS_W-1:0]        position_ref,
  output logic [REF_W-1:0]        texcoord_ref,
  output logic [REF_W-1:0]        normal_ref,
  output logic                    last
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int IW = $clog2(MAX_CORNERS);
  localparam int CW = $clog2(MAX_CORNERS + 1);
  localparam int unsigned VLIM = (MAX_VERTICES < TABLE_ENTRIES) ? MAX_VERTICES : TABLE_ENTRIES;
  localparam int NVW = $clog2(VLIM + 1);
  localparam logic [NVW:0] VLIM_V = (NVW + 1)'(VLIM);
  localparam logic [AW-1:0] TBL_LAST = AW'(TABLE_ENTRIES - 1);
  localparam logic [1:0] HC_LAST = 2'(MUL_STEPS - 1);

  // Returns {ok, zero-based index}.
  function automatic logic [CNT_W:0] resolve(input logic signed [RAW_W-1:0] r,
                                             input logic [CNT_W-1:0] c);
    logic signed [RAW_W:0] x;
    logic ok;
    if (r > 0) begin
      x = {r[RAW_W-1], r} - 23'sd1;
    end else begin
      x = $signed({2'b00, c}) + $signed({r[RAW_W-1], r});
    end
    ok = (r != 0) && (x >= 0) && (x < $signed({2'b00, c}));
    return {ok, x[CNT_W-1:0]};
  endfunction

  logic [CW-1:0]    count;
  logic             bad;
  logic [NVW-1:0]   nv;
  logic [CW-1:0]    fresh;
  logic [IW-1:0]    ci;
  logic [KEY_W-1:0] keys  [MAX_CORNERS];
  logic [AW-1:0]    home  [MAX_CORNERS];
  logic [IDX_W-1:0] idxs  [MAX_CORNERS];
  logic             isnew [MAX_CORNERS];

  logic             hbusy;
  logic [1:0]       hcnt;
  logic [HASH_W-1:0] h;
  logic [AW-1:0]    slot;
  logic [AW-1:0]    pcnt;
  logic [AW-1:0]    clr_addr;

  // Corner resolution.
  logic [CNT_W:0] rp, rt, rn;
  logic           pos_bad;
  logic [KEY_W-1:0] new_key;
  always_comb begin
    rp = resolve(raw_position, position_count);
    rt = resolve(raw_texcoord, texcoord_count);
    rn = resolve(raw_normal, normal_count);
    pos_bad = !rp[CNT_W] || rp[POS_W];
    new_key = {rn[CNT_W] ? REF_W'(rn[CNT_W-1:0] + 21'd1) : '0,
               rt[CNT_W] ? REF_W'(rt[CNT_W-1:0] + 21'd1) : '0,
               rp[POS_W-1:0]};
  end

  // Hash unit: three shared multiply steps; the home slot is the low hash bits.
  logic [KEY_W-1:0]  cur_key;
  logic [REF_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_k;
  logic [HASH_W-1:0] prod;
  logic [HASH_W-1:0] h_next;
  assign cur_key = keys[ci];
  always_comb begin
    case (hcnt)
      2'd0: begin
        mul_a = {1'b0, cur_key[POS_W-1:0]} + 21'd1;
        mul_k = HASH_K_POS;
      end
      2'd1: begin
        mul_a = cur_key[POS_W+REF_W-1:POS_W];
        mul_k = HASH_K_TEX;
      end
      default: begin
        mul_a = cur_key[KEY_W-1:POS_W+REF_W];
        mul_k = HASH_K_NRM;
      end
    endcase
    prod   = HASH_W'(mul_a) * HASH_W'(mul_k);
    h_next = h ^ prod;
  end

  // Table RAM.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               rd_valid;
  logic [KEY_W-1:0]   rd_key;
  logic [IDX_W-1:0]   rd_idx;
  logic               match;

  assign rd_valid = ram_rdata[ENTRY_W-1];
  assign rd_key   = ram_rdata[ENTRY_W-2:IDX_W];
  assign rd_idx   = ram_rdata[IDX_W-1:0];
  assign match    = rd_key == cur_key;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    if (cmd.clr_step) begin
      ram_we = 1'b1;
    end else if (cmd.ins_write && !rd_valid) begin
      ram_we    = 1'b1;
      ram_waddr = slot;
      ram_wdata = {1'b1, cur_key, idxs[ci]};
    end
  end

  fvd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.probe_read),
    .raddr(slot),
    .rdata(ram_rdata)
  );

  // Earlier corner with the same key.
  logic          dup;
  logic [IW-1:0] dup_j;
  always_comb begin
    dup   = 1'b0;
    dup_j = '0;
    for (int j = 0; j < MAX_CORNERS; j++) begin
      if (!dup && IW'(j) < ci && keys[j] == cur_key) begin
        dup   = 1'b1;
        dup_j = IW'(j);
      end
    end
  end

  logic [NVW:0]     nv_sum;
  logic             hit;
  logic [IW-1:0]    ci1;
  logic             out_free;
  assign nv_sum   = (NVW + 1)'(nv) + (NVW + 1)'(fresh);
  assign hit      = rd_valid && match;
  assign ci1      = IW'(ci + IW'(1));
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    st.clr_done   = clr_addr == TBL_LAST;
    st.too_few    = count < CW'(3);
    st.bad        = bad;
    st.hash_busy  = hbusy;
    st.idx_last   = CW'(ci) + CW'(1) == count;
    st.probe_stop = !rd_valid || match || (pcnt == TBL_LAST);
    st.full_fail  = nv_sum > VLIM_V;
    st.cur_new    = isnew[ci];
    st.tri_last   = CW'(ci) + CW'(2) >= count;
    st.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      bad       <= 1'b0;
      nv        <= '0;
      fresh     <= '0;
      hbusy     <= 1'b0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_start) begin
        count    <= '0;
        bad      <= 1'b0;
        nv       <= '0;
        fresh    <= '0;
        clr_addr <= '0;
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.take_corner && count < CW'(MAX_CORNERS)) begin
        keys[count[IW-1:0]] <= pos_bad ? '0 : new_key;
        bad   <= bad | pos_bad;
        count <= count + CW'(1);
      end
      if (cmd.p1_record) begin
        isnew[ci] <= !hit && !dup;
        if (hit) begin
          idxs[ci] <= rd_idx;
        end else if (dup) begin
          idxs[ci] <= idxs[dup_j];
        end else begin
          idxs[ci] <= IDX_W'(nv_sum);
          fresh    <= fresh + CW'(1);
        end
      end
      if (cmd.commit) begin
        nv <= NVW'(nv_sum);
      end
      if (cmd.face_end) begin
        count <= '0;
        bad   <= 1'b0;
        fresh <= '0;
      end

      // Hash unit.
      if (cmd.hash_start) begin
        hbusy <= 1'b1;
        hcnt  <= '0;
        h     <= '0;
      end else if (hbusy) begin
        h <= h_next;
        if (hcnt == HC_LAST) begin
          hbusy    <= 1'b0;
          home[ci] <= h_next[AW-1:0];
        end
        hcnt <= hcnt + 2'd1;
      end

      // Result register: load on emit, drop on transfer.
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end

    if (cmd.idx_rst) begin
      ci <= '0;
    end else if (cmd.idx_one) begin
      ci <= IW'(1);
    end else if (cmd.idx_inc) begin
      ci <= ci1;
    end

    if (cmd.probe_start) begin
      slot <= home[ci];
      pcnt <= '0;
    end else if (cmd.probe_next) begin
      slot <= (slot == TBL_LAST) ? '0 : slot + AW'(1);
      pcnt <= pcnt + AW'(1);
    end

    if (cmd.emit) begin
      unique case (cmd.emit_sel)
        EMIT_VERTEX: begin
          kind         <= KIND_VERTEX;
          index_a      <= idxs[ci];
          index_b      <= '0;
          index_c      <= '0;
          position_ref <= cur_key[POS_W-1:0];
          texcoord_ref <= cur_key[POS_W+REF_W-1:POS_W];
          normal_ref   <= cur_key[KEY_W-1:POS_W+REF_W];
          last         <= 1'b0;
        end
        EMIT_TRIANGLE: begin
          kind         <= KIND_TRIANGLE;
          index_a      <= idxs[0];
          index_b      <= idxs[ci];
          index_c      <= idxs[ci1];
          position_ref <= '0;
          texcoord_ref <= '0;
          normal_ref   <= '0;
          last         <= CW'(ci) + CW'(2) >= count;
        end
        default: begin
          kind         <= cmd.rej_kind;
          index_a      <= '0;
          index_b      <= '0;
          index_c      <= '0;
          position_ref <= '0;
          texcoord_ref <= '0;
          normal_ref   <= '0;
          last         <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- design/fvd_ctrl.sv -----
// Controller: sequences clearing, corner intake, hashing, probing, inserts and emission.
module fvd_ctrl
  import fvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        opcode,
  input  logic        last_corner,
  output logic        in_stall,
  input  fvd_status_t st,
  output fvd_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EVAL, S_HASH, S_P1_START, S_P1_RD, S_P1_CMP, S_FULL_CHK,
    S_P2_SEL, S_P2_RD, S_P2_CMP, S_EMIT_V, S_TRI, S_REJ
  } state_t;

  state_t state, state_next;
  kind_t  rej_kind, rej_kind_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd           = '0;
    cmd.rej_kind  = rej_kind;
    cmd.emit_sel  = EMIT_REJECT;
    state_next    = state;
    rej_kind_next = rej_kind;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_CLEAR) begin
            cmd.clr_start = 1'b1;
            state_next    = S_CLEAR;
          end else begin
            cmd.take_corner = 1'b1;
            if (last_corner) state_next = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (st.too_few) begin
          rej_kind_next = KIND_TOO_FEW;
          state_next    = S_REJ;
        end else if (st.bad) begin
          rej_kind_next = KIND_BAD_CORNER;
          state_next    = S_REJ;
        end else begin
          cmd.idx_rst    = 1'b1;
          cmd.hash_start = 1'b1;
          state_next     = S_HASH;
        end
      end
      S_HASH: begin
        if (!st.hash_busy) begin
          if (st.idx_last) begin
            cmd.idx_rst = 1'b1;
            state_next  = S_P1_START;
          end else begin
            cmd.idx_inc    = 1'b1;
            cmd.hash_start = 1'b1;
          end
        end
      end
      S_P1_START: begin
        cmd.probe_start = 1'b1;
        state_next      = S_P1_RD;
      end
      S_P1_RD: begin
        cmd.probe_read = 1'b1;
        state_next     = S_P1_CMP;
      end
      S_P1_CMP: begin
        if (st.probe_stop) begin
          cmd.p1_record = 1'b1;
          if (st.idx_last) begin
            state_next = S_FULL_CHK;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_P1_START;
          end
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_P1_RD;
        end
      end
      S_FULL_CHK: begin
        if (st.full_fail) begin
          rej_kind_next = KIND_TABLE_FULL;
          state_next    = S_REJ;
        end else begin
          cmd.idx_rst = 1'b1;
          state_next  = S_P2_SEL;
        end
      end
      S_P2_SEL: begin
        if (st.cur_new) begin
          cmd.probe_start = 1'b1;
          state_next      = S_P2_RD;
        end else if (st.idx_last) begin
          cmd.idx_one = 1'b1;
          state_next  = S_TRI;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_P2_RD: begin
        cmd.probe_read = 1'b1;
        state_next     = S_P2_CMP;
      end
      S_P2_CMP: begin
        if (st.probe_stop) begin
          cmd.ins_write = 1'b1;
          state_next    = S_EMIT_V;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_P2_RD;
        end
      end
      S_EMIT_V: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_VERTEX;
          if (st.idx_last) begin
            cmd.idx_one = 1'b1;
            state_next  = S_TRI;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_P2_SEL;
          end
        end
      end
      S_TRI: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_TRIANGLE;
          if (st.tri_last) begin
            cmd.commit   = 1'b1;
            cmd.face_end = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_REJ: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.face_end = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      rej_kind <= KIND_TOO_FEW;
    end else begin
      state    <= state_next;
      rej_kind <= rej_kind_next;
    end
  end

endmodule

// ----- design/face_vertex_dedup_fan_triangulator.sv -----
// Top level of the face vertex deduplicator and fan triangulator.
//
// Corners of a polygon face arrive one transfer at a time; a corner that is
// not the last of its face is taken while the block stays idle and gives no
// result. The last corner starts the face work: an evaluation state checks
// the corner count and the bad flag, then each buffered corner (at most
// MAX_CORNERS) is hashed by one shared multiplier in three steps followed by
// a hand-off. The home slot is the low bits of the hash, so TABLE_ENTRIES
// must be a power of two. Each corner then probes the key table on the
// single read port: it loads its home slot, then reads and compares each
// slot visited. A table-full check follows; then each new vertex probes
// again (a select state, then a read and a compare per slot visited) and is
// inserted on its last compare and emitted from its own state, while a
// corner that is not new passes through the select state alone. Results
// leave through one output register, at most one per cycle: new vertex
// records in corner order, then the fan triangles one per cycle while
// out_stall is low, or instead one rejection record from a reject state.
// A result waiting under out_stall holds the sequence back. After reset
// and after every clear transfer (opcode 1) the table RAM is swept, one
// entry per cycle over all TABLE_ENTRIES entries, during which in_stall
// stays high.
module face_vertex_dedup_fan_triangulator
  import fvd_pkg::*;
#(
  parameter int unsigned MAX_VERTICES  = MAX_VERTICES_DEF,
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_CORNERS   = MAX_CORNERS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    opcode,
  input  logic signed [RAW_W-1:0] raw_position,
  input  logic signed [RAW_W-1:0] raw_texcoord,
  input  logic signed [RAW_W-1:0] raw_normal,
  input  logic [CNT_W-1:0]        position_count,
  input  logic [CNT_W-1:0]        texcoord_count,
  input  logic [CNT_W-1:0]        normal_count,
  input  logic                    last_corner,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              kind,
  output logic [IDX_W-1:0]        index_a,
  output logic [IDX_W-1:0]        index_b,
  output logic [IDX_W-1:0]        index_c,
  output logic [POS_W-1:0]        position_ref,
  output logic [REF_W-1:0]        texcoord_ref,
  output logic [REF_W-1:0]        normal_ref,
  output logic                    last
);

  fvd_cmd_t    cmd;
  fvd_status_t st;

  // Controller: owns the input handshake; accepts only while idle.
  fvd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .opcode     (opcode),
    .last_corner(last_corner),
    .in_stall   (in_stall),
    .st         (st),
    .cmd        (cmd)
  );

  // Datapath: corner buffer, hash, table, result register.
  fvd_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_CORNERS  (MAX_CORNERS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .raw_position  (raw_position),
    .raw_texcoord  (raw_texcoord),
    .raw_normal    (raw_normal),
    .position_count(position_count),
    .texcoord_count(texcoord_count),
    .normal_count  (normal_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .index_a       (index_a),
    .index_b       (index_b),
    .index_c       (index_c),
    .position_ref  (position_ref),
    .texcoord_ref  (texcoord_ref),
    .normal_ref    (normal_ref),
    .last          (last)
  );

endmodule

// ----- design/fvd_checker.sv -----
// Port-level checker for the face vertex deduplicator, bound to the top level.
module fvd_checker
  import fvd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        opcode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  kind,
  input logic [15:0] index_a,
  input logic [15:0] index_b,
  input logic [15:0] index_c,
  input logic [19:0] position_ref,
  input logic [20:0] texcoord_ref,
  input logic [20:0] normal_ref,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(index_a) && $stable(last))
    else $error("stalled result changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_BAD_CORNER || kind == KIND_TOO_FEW || kind == KIND_TABLE_FULL)
    |-> last && index_a == 0 && index_b == 0 && index_c == 0 && position_ref == 0
        && texcoord_ref == 0 && normal_ref == 0)
    else $error("rejection record not clean");

  a_vertex_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_VERTEX |-> !last && index_b == 0 && index_c == 0)
    else $error("vertex record malformed");

  a_tri_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_TRIANGLE |-> position_ref == 0 && texcoord_ref == 0
        && normal_ref == 0)
    else $error("triangle record carries refs");

  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == OP_CLEAR |=> in_stall)
    else $error("clear transfer did not start table sweep");

endmodule

bind face_vertex_dedup_fan_triangulator fvd_checker u_fvd_checker (.*);
